// File: sv/grq_pkg.sv
// Shared types, constants and the gear lookup for the gear request qualifier.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package grq_pkg;

  // Number of button positions that a message can carry.
  localparam int NUM_BUTTONS = 16;

  // Field widths.
  localparam int BITS_W  = 16;
  localparam int COUNT_W = 5;
  localparam int SPEED_W = 16;
  localparam int IDX_W   = 4;
  localparam int GEAR_W  = 3;
  localparam int LIMIT_W = 15;

  // Configuration port widths.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 15;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_IDX   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEUTRAL_IDX = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE_IDX = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PARK_IDX    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_INIT_GEAR   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SPEED   = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [IDX_W-1:0]   DRIVE_IDX_RST   = 4'd0;
  localparam logic [IDX_W-1:0]   NEUTRAL_IDX_RST = 4'd1;
  localparam logic [IDX_W-1:0]   REVERSE_IDX_RST = 4'd2;
  localparam logic [IDX_W-1:0]   PARK_IDX_RST    = 4'd3;
  localparam logic [GEAR_W-1:0]  INIT_GEAR_RST   = 3'd1;
  localparam logic [LIMIT_W-1:0] MAX_SPEED_RST   = 15'd500;

  // Gear codes.
  localparam logic [GEAR_W-1:0] GEAR_PARK    = 3'd1;
  localparam logic [GEAR_W-1:0] GEAR_REVERSE = 3'd2;
  localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 3'd3;
  localparam logic [GEAR_W-1:0] GEAR_DRIVE   = 3'd4;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_BAD_MSG   = 3'd1,
    ST_AMBIGUOUS = 3'd2,
    ST_NO_SPEED  = 3'd3,
    ST_TOO_FAST  = 3'd4,
    ST_CHANGED   = 3'd5
  } status_t;

  // Live configuration, in the button order drive, neutral, reverse, park.
  typedef struct packed {
    logic [3:0][IDX_W-1:0] btn_idx;
    logic [LIMIT_W-1:0]    max_speed;
    logic                  gear_load;
    logic [GEAR_W-1:0]     gear_value;
  } cfg_t;

  // Outcome of evaluating one sample against the held state.
  typedef struct packed {
    logic              bad_msg;
    logic [3:0]        pressed;
    logic              change;
    logic [GEAR_W-1:0] new_gear;
    status_t           status;
  } eval_t;

  // Gear selected by a press of button slot 0..3.
  function automatic logic [GEAR_W-1:0] gear_of_button(input logic [1:0] slot);
    logic [GEAR_W-1:0] g;
    unique case (slot)
      2'd0: g = GEAR_DRIVE;
      2'd1: g = GEAR_NEUTRAL;
      2'd2: g = GEAR_REVERSE;
      2'd3: g = GEAR_PARK;
      default: g = GEAR_PARK;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: sv/gear_request_qualifier_unit.sv
// Top level of the gear request qualifier: input register, state, result register.
// Depends on grq_pkg, grq_cfg and grq_eval.
//
// Usage:
//   Sample channel: sample_valid/sample_stall with button_bits, button_count,
//   speed_ok and speed_mmps. A beat moves when valid is high and stall is low.
//   Result channel: result_valid/result_stall with gear_now and status, one
//   result beat for every sample beat, in order.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Writing the initial gear register loads the current gear.
//   Write configuration only while no sample is in flight.
// Flow and throughput:
//   A sample is captured in the input register, evaluated combinationally against the
//   held press pattern, and its result is loaded into the result register when that
//   register is free or emptying. One sample is taken per cycle while no result stall
//   holds; the single evaluation stage between the two registers sets that rate.
// Reset: rst is synchronous; both registers empty, press pattern cleared,
//   gear set to park, configuration registers to their defaults.
// Stall: a stalled result holds; the input register fills behind it and then
//   sample_stall rises in the same cycle until the result beat moves.
`default_nettype none

module gear_request_qualifier_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  output logic                                 sample_stall,
  input  wire logic [grq_pkg::BITS_W-1:0]      button_bits,
  input  wire logic [grq_pkg::COUNT_W-1:0]     button_count,
  input  wire logic                            speed_ok,
  input  wire logic signed [grq_pkg::SPEED_W-1:0] speed_mmps,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic [grq_pkg::GEAR_W-1:0]           gear_now,
  output logic [2:0]                           status,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [grq_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  wire logic [grq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  grq_pkg::cfg_t               cfg;
  grq_pkg::eval_t              ev;

  logic                        s1_valid;
  logic [grq_pkg::BITS_W-1:0]  s1_bits;
  logic [grq_pkg::COUNT_W-1:0] s1_count;
  logic                        s1_speed_ok;
  logic [grq_pkg::SPEED_W-1:0] s1_speed;

  logic [3:0]                  prev_pressed;
  logic [grq_pkg::GEAR_W-1:0]  gear_reg;
  logic [grq_pkg::GEAR_W-1:0]  gear_reg_next;

  logic                        adv;
  logic                        take;

  grq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  grq_eval u_eval (
    .cfg          (cfg),
    .button_bits  (s1_bits),
    .button_count (s1_count),
    .speed_ok     (s1_speed_ok),
    .speed_mmps   (s1_speed),
    .prev_pressed (prev_pressed),
    .res          (ev)
  );

  // Handshake: the held sample moves on when the result register is free or emptying.
  assign adv          = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !adv;
  assign take         = sample_valid && !sample_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take || (s1_valid && !adv);
    end
    if (take) begin
      s1_bits     <= button_bits;
      s1_count    <= button_count;
      s1_speed_ok <= speed_ok;
      s1_speed    <= speed_mmps;
    end
  end

  // Gear after this sample.
  always_comb begin
    gear_reg_next = gear_reg;
    if (adv && ev.change) begin
      gear_reg_next = ev.new_gear;
    end
  end

  // Held state: press pattern and current gear.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pressed <= '0;
      gear_reg     <= grq_pkg::INIT_GEAR_RST;
    end else begin
      if (adv && !ev.bad_msg) begin
        prev_pressed <= ev.pressed;
      end
      if (cfg.gear_load) begin
        gear_reg <= cfg.gear_value;
      end else begin
        gear_reg <= gear_reg_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (adv) begin
      gear_now <= gear_reg_next;
      status   <= ev.status;
    end
  end

  // The input side only stalls when both registers are occupied.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (s1_valid && result_valid && result_stall))
    else $error("sample_stall raised with a free register");

  // A reported change always carries one of the four gear codes.
  a_change_gear_legal: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == grq_pkg::ST_CHANGED) |->
      (gear_now == grq_pkg::GEAR_PARK || gear_now == grq_pkg::GEAR_REVERSE ||
       gear_now == grq_pkg::GEAR_NEUTRAL || gear_now == grq_pkg::GEAR_DRIVE))
    else $error("change reported with an illegal gear");

  // A short message leaves the press pattern untouched.
  a_bad_msg_keeps_pattern: assert property (@(posedge clk) disable iff (rst)
    (adv && ev.bad_msg) |=> $stable(prev_pressed))
    else $error("press pattern updated by a short message");

endmodule

`default_nettype wire

// File: sv/grq_cfg.sv
// Configuration register file of the gear request qualifier.
// Depends on grq_pkg for widths, register indexes and reset values.
`default_nettype none

module grq_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [grq_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  wire logic [grq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output grq_pkg::cfg_t                        cfg
);

  logic [3:0][grq_pkg::IDX_W-1:0] btn_idx;
  logic [grq_pkg::LIMIT_W-1:0]    max_speed;
  logic                           wr;

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      btn_idx[0] <= grq_pkg::DRIVE_IDX_RST;
      btn_idx[1] <= grq_pkg::NEUTRAL_IDX_RST;
      btn_idx[2] <= grq_pkg::REVERSE_IDX_RST;
      btn_idx[3] <= grq_pkg::PARK_IDX_RST;
      max_speed  <= grq_pkg::MAX_SPEED_RST;
    end else if (wr) begin
      unique case (cfg_index)
        grq_pkg::CFG_DRIVE_IDX:   btn_idx[0] <= cfg_data[grq_pkg::IDX_W-1:0];
        grq_pkg::CFG_NEUTRAL_IDX: btn_idx[1] <= cfg_data[grq_pkg::IDX_W-1:0];
        grq_pkg::CFG_REVERSE_IDX: btn_idx[2] <= cfg_data[grq_pkg::IDX_W-1:0];
        grq_pkg::CFG_PARK_IDX:    btn_idx[3] <= cfg_data[grq_pkg::IDX_W-1:0];
        grq_pkg::CFG_MAX_SPEED:   max_speed  <= cfg_data[grq_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // The initial gear is only ever used at the moment it is written, as a load of the gear.
  always_comb begin
    cfg.btn_idx    = btn_idx;
    cfg.max_speed  = max_speed;
    cfg.gear_load  = wr && (cfg_index == grq_pkg::CFG_INIT_GEAR);
    cfg.gear_value = cfg_data[grq_pkg::GEAR_W-1:0];
  end

endmodule

`default_nettype wire

// File: sv/grq_eval.sv
// Combinational evaluation of one button sample against the held press pattern.
// Depends on grq_pkg for the configuration and result structs and the gear lookup.
`default_nettype none

module grq_eval (
  input  wire grq_pkg::cfg_t                  cfg,
  input  wire logic [grq_pkg::BITS_W-1:0]     button_bits,
  input  wire logic [grq_pkg::COUNT_W-1:0]    button_count,
  input  wire logic                           speed_ok,
  input  wire logic [grq_pkg::SPEED_W-1:0]    speed_mmps,
  input  wire logic [3:0]                     prev_pressed,
  output grq_pkg::eval_t                      res
);

  logic                        short_msg;
  logic [3:0]                  pressed;
  logic [3:0]                  rising;
  logic [1:0]                  req;
  logic [grq_pkg::SPEED_W-1:0] mag;
  logic                        too_fast;

  // Message length check and button pick, one slot per configured position.
  always_comb begin
    short_msg = 1'b0;
    pressed   = '0;
    for (int i = 0; i < 4; i++) begin
      if ({1'b0, cfg.btn_idx[i]} >= button_count ||
          {1'b0, cfg.btn_idx[i]} >= grq_pkg::COUNT_W'(grq_pkg::NUM_BUTTONS)) begin
        short_msg = 1'b1;
      end
      pressed[i] = button_bits[cfg.btn_idx[i]];
    end
  end

  // Rising edges and the slot that rose; only used when exactly one rose.
  always_comb begin
    rising = pressed & ~prev_pressed;
    req    = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (rising[i]) begin
        req = 2'(i);
      end
    end
  end

  // Speed magnitude; the most negative value maps to 32768, above any limit.
  always_comb begin
    mag      = speed_mmps[grq_pkg::SPEED_W-1] ? (~speed_mmps + 1'b1) : speed_mmps;
    too_fast = mag > {1'b0, cfg.max_speed};
  end

  // Status decision in priority order.
  always_comb begin
    res.bad_msg  = short_msg;
    res.pressed  = pressed;
    res.change   = 1'b0;
    res.new_gear = grq_pkg::gear_of_button(req);
    priority if (short_msg) begin
      res.status = grq_pkg::ST_BAD_MSG;
    end else if (rising == 4'd0) begin
      res.status = grq_pkg::ST_NONE;
    end else if (!$onehot(pressed) || !$onehot(rising)) begin
      res.status = grq_pkg::ST_AMBIGUOUS;
    end else if (!speed_ok) begin
      res.status = grq_pkg::ST_NO_SPEED;
    end else if (too_fast) begin
      res.status = grq_pkg::ST_TOO_FAST;
    end else begin
      res.status = grq_pkg::ST_CHANGED;
      res.change = 1'b1;
    end
  end

endmodule

`default_nettype wire
